[src/sqmm_pkg.sv]
// ----------------------------------------------------------------------------
// sqmm_pkg
// Element, product and accumulator types for the square matrix multiplier.
// ----------------------------------------------------------------------------
package sqmm_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 35;
  localparam int IDX_W  = 3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic        [IDX_W-1:0]  idx_t;

endpackage

[src/square_matrix_multiply_core.sv]
// Loads two MATRIX_SIZE x MATRIX_SIZE signed matrices, one element of each per
// input beat in row-major order, then emits every element of their product in
// row-major order, each with its row, column and a flag on the final element.
// While loading, a beat is taken whenever in_valid is high. After the last beat
// the input is stalled while a single multiply-accumulate unit works through
// the product: each product element takes MATRIX_SIZE store reads, which pass
// through the registered read, multiply and accumulate stages, and the
// finished sum is held until the output can take it.
// The block then loads a fresh pair.
// ----------------------------------------------------------------------------
// square_matrix_multiply_core
// Square integer matrix multiplier built around one shared multiply-accumulate.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core #(
  parameter int MATRIX_SIZE = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sqmm_pkg::elem_t  first_elem,
  input  sqmm_pkg::elem_t  second_elem,
  output logic             out_valid,
  input  logic             out_stall,
  output sqmm_pkg::idx_t   row_index,
  output sqmm_pkg::idx_t   col_index,
  output sqmm_pkg::acc_t   product_value,
  output logic             last_of_run
);

  import sqmm_pkg::*;

  localparam int DEPTH = MATRIX_SIZE * MATRIX_SIZE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam logic [AW-1:0] N_A      = AW'(MATRIX_SIZE);
  localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MATRIX_SIZE - 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_DRAIN
  } state_t;

  state_t        state;
  logic [AW-1:0] load_count;
  logic [IW-1:0] row_i;
  logic [IW-1:0] col_j;
  logic [IW-1:0] k_cnt;

  elem_t first_store  [DEPTH];
  elem_t second_store [DEPTH];

  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic          in_beat;
  logic          rd_en;
  logic          out_free;
  logic          out_load;

  // MAC pipeline
  elem_t a_q;
  elem_t b_q;
  logic  v1, first1, last1;
  prod_t prod_q;
  logic  v2, first2, last2;
  acc_t  acc;
  logic  acc_done;

  assign in_stall = (state != S_LOAD);
  assign in_beat  = in_valid && !in_stall;
  assign rd_en    = (state == S_ISSUE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DRAIN) && acc_done && out_free;

  always_comb begin
    addr_a = AW'(row_i) * N_A + AW'(k_cnt);
    addr_b = AW'(k_cnt) * N_A + AW'(col_j);
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      first_store[load_count]  <= first_elem;
      second_store[load_count] <= second_elem;
    end
    a_q <= first_store[addr_a];
    b_q <= second_store[addr_b];
  end

  always_ff @(posedge clk) begin
    prod_q <= PROD_W'(a_q) * PROD_W'(b_q);
    if (v2) begin
      if (first2) begin
        acc <= ACC_W'(prod_q);
      end else begin
        acc <= acc + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      row_i      <= '0;
      col_j      <= '0;
      k_cnt      <= '0;
      v1         <= 1'b0;
      first1     <= 1'b0;
      last1      <= 1'b0;
      v2         <= 1'b0;
      first2     <= 1'b0;
      last2      <= 1'b0;
      acc_done   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      v1     <= rd_en;
      first1 <= rd_en && (k_cnt == '0);
      last1  <= rd_en && (k_cnt == LAST_IDX);
      v2     <= v1;
      first2 <= first1;
      last2  <= last1;
      if (v2 && last2) begin
        acc_done <= 1'b1;
      end

      // drop the taken beat unless a fresh one replaces it
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (load_count == LAST_A) begin
              load_count <= '0;
              row_i      <= '0;
              col_j      <= '0;
              k_cnt      <= '0;
              state      <= S_ISSUE;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_ISSUE: begin
          if (k_cnt == LAST_IDX) begin
            k_cnt <= '0;
            state <= S_DRAIN;
          end else begin
            k_cnt <= k_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            acc_done      <= 1'b0;
            out_valid     <= 1'b1;
            row_index     <= IDX_W'(row_i);
            col_index     <= IDX_W'(col_j);
            product_value <= acc;
            last_of_run   <= (row_i == LAST_IDX) && (col_j == LAST_IDX);
            // advance to the next product element, or back to loading
            if (col_j == LAST_IDX) begin
              col_j <= '0;
              if (row_i == LAST_IDX) begin
                row_i <= '0;
                state <= S_LOAD;
              end else begin
                row_i <= row_i + 1'b1;
                state <= S_ISSUE;
              end
            end else begin
              col_j <= col_j + 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Assertions
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |->
      row_index == IDX_W'(MATRIX_SIZE - 1) && col_index == IDX_W'(MATRIX_SIZE - 1))
    else $error("last_of_run on a product element that is not the final corner");

  a_idle_mac_on_load: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> !v1 && !v2 && !acc_done)
    else $error("input beat taken while the MAC pipeline is busy");

  a_full_load_starts: assert property (@(posedge clk) disable iff (rst)
    in_beat && load_count == LAST_A |=> state == S_ISSUE && load_count == '0)
    else $error("final load beat did not start the product sweep");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == S_DRAIN)
    else $error("finished sum outside the drain phase");

endmodule
